### src/sbss_pkg.sv
// Shared types, constants and helper functions of the sparse block span statistics block.
`default_nettype none

package sbss_pkg;

  // Fixed field widths.
  localparam int ROW_W = 31;
  localparam int SLOT_W = 6;
  localparam int SLOTS = 1 << SLOT_W;
  localparam int CNT_W = 32;
  localparam int SPAN_W = 32;
  localparam int STRIDE_W = 7;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = STRIDE_W;
  localparam logic [CFG_ADDR_W-1:0] CFG_STRIDE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_OFF = 1'd1;

  localparam int SBSS_MAX_STRIDE = 64;

  localparam logic signed [SPAN_W-1:0] SPAN_TOP = 32'sh7fff_ffff;
  localparam int N_LIMITS = 4;
  localparam logic signed [SPAN_W-1:0] SPAN_LIMITS [N_LIMITS] = '{
    32'sd4, 32'sd8, 32'sd16, 32'sd32
  };

  // What one entry did to the block tracking.
  typedef struct packed {
    logic                     closed;
    logic                     partial;
    logic                     repeat_hit;
    logic signed [SPAN_W-1:0] span;
  } blk_event_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

### src/sbss_ifs.sv
// Stream and configuration interfaces of the sparse block span statistics block.
`default_nettype none

interface sbss_in_if import sbss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_index;
  logic [SLOT_W-1:0] slot;
  logic              stripe_end;

  modport source (output valid, row_index, slot, stripe_end, input ready);
  modport sink (input valid, row_index, slot, stripe_end, output ready);
endinterface

interface sbss_out_if import sbss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     block_closed;
  logic [CNT_W-1:0]         full_blocks;
  logic signed [SPAN_W-1:0] min_span;
  logic signed [SPAN_W-1:0] max_span;
  logic [CNT_W-1:0]         span_le_4;
  logic [CNT_W-1:0]         span_le_8;
  logic [CNT_W-1:0]         span_le_16;
  logic [CNT_W-1:0]         span_le_32;
  logic [CNT_W-1:0]         partial_blocks;
  logic [CNT_W-1:0]         collision_blocks;

  modport source (output valid, block_closed, full_blocks, min_span, max_span,
                  span_le_4, span_le_8, span_le_16, span_le_32, partial_blocks,
                  collision_blocks, input ready);
  modport sink (input valid, block_closed, full_blocks, min_span, max_span,
                span_le_4, span_le_8, span_le_16, span_le_32, partial_blocks,
                collision_blocks, output ready);
endinterface

interface sbss_cfg_if import sbss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### src/sbss_tracker.sv
// Block fill tracking: fill count, first row, slot occupancy and span of a closing block.
`default_nettype none

module sbss_tracker import sbss_pkg::*; #(
  parameter int MAX_STRIDE = SBSS_MAX_STRIDE
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   fire,
  input  wire logic [ROW_W-1:0]                       row_index,
  input  wire logic [SLOT_W-1:0]                      slot,
  input  wire logic                                   stripe_end,
  input  wire logic [((($clog2(MAX_STRIDE+1)) > STRIDE_W) ?
                      $clog2(MAX_STRIDE+1) : STRIDE_W)-1:0] stride_eff,
  input  wire logic                                   check_off,
  output blk_event_t                                  ev
);

  localparam int FW = $clog2(MAX_STRIDE + 1);
  localparam int CW = (FW > STRIDE_W) ? FW : STRIDE_W;

  logic [FW-1:0]    fill_r, fill_nxt, fill_inc;
  logic [ROW_W-1:0] first_r, first_nxt;
  logic [SLOTS-1:0] seen_r, seen_nxt, seen_base, slot_bit;
  logic             rep_r, rep_nxt, rep_base;
  logic             start;
  logic signed [SPAN_W:0] wide;

  always_comb begin
    start     = (fill_r == '0);
    seen_base = start ? '0 : seen_r;
    rep_base  = start ? 1'b0 : rep_r;
    first_nxt = start ? row_index : first_r;
    slot_bit  = {{(SLOTS-1){1'b0}}, 1'b1} << slot;
    if (!check_off) begin
      rep_nxt  = rep_base | (|(seen_base & slot_bit));
      seen_nxt = seen_base | slot_bit;
    end else begin
      rep_nxt  = rep_base;
      seen_nxt = seen_base;
    end
    fill_inc = fill_r + 1'b1;
    ev.closed     = (CW'(fill_inc) >= stride_eff);
    ev.partial    = !ev.closed && stripe_end;
    ev.repeat_hit = rep_nxt;
    // Span in one extra bit so that the largest positive case can saturate.
    wide = $signed({2'b00, row_index}) - $signed({2'b00, first_nxt}) + 33'sd1;
    ev.span = (wide > $signed({1'b0, SPAN_TOP})) ? SPAN_TOP : wide[SPAN_W-1:0];
    fill_nxt = (ev.closed || ev.partial) ? '0 : fill_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rep_r  <= 1'b0;
      seen_r <= '0;
    end else if (fire) begin
      fill_r <= fill_nxt;
      rep_r  <= rep_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

### src/sbss_stats.sv
// Running span statistics; the counters double as the result register.
`default_nettype none

module sbss_stats import sbss_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire blk_event_t                ev,
  output logic                           block_closed,
  output logic [CNT_W-1:0]               full_blocks,
  output logic signed [SPAN_W-1:0]       min_span,
  output logic signed [SPAN_W-1:0]       max_span,
  output logic [CNT_W-1:0]               span_le [N_LIMITS],
  output logic [CNT_W-1:0]               partial_blocks,
  output logic [CNT_W-1:0]               collision_blocks
);

  logic                     closed_r;
  logic [CNT_W-1:0]         total_r, partial_r, coll_r;
  logic signed [SPAN_W-1:0] min_r, max_r;
  logic [CNT_W-1:0]         thr_r [N_LIMITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r  <= 1'b0;
      total_r   <= '0;
      partial_r <= '0;
      coll_r    <= '0;
      min_r     <= SPAN_TOP;
      max_r     <= '0;
      for (int k = 0; k < N_LIMITS; k++) begin
        thr_r[k] <= '0;
      end
    end else if (fire) begin
      closed_r <= ev.closed;
      if (ev.closed) begin
        total_r <= sat_inc(total_r);
        if (ev.span < min_r) begin
          min_r <= ev.span;
        end
        if (ev.span > max_r) begin
          max_r <= ev.span;
        end
        for (int k = 0; k < N_LIMITS; k++) begin
          if (ev.span <= SPAN_LIMITS[k]) begin
            thr_r[k] <= sat_inc(thr_r[k]);
          end
        end
        if (ev.repeat_hit) begin
          coll_r <= sat_inc(coll_r);
        end
      end
      if (ev.partial) begin
        partial_r <= sat_inc(partial_r);
      end
    end
  end

  assign block_closed     = closed_r;
  assign full_blocks      = total_r;
  assign min_span         = min_r;
  assign max_span         = max_r;
  assign span_le          = thr_r;
  assign partial_blocks   = partial_r;
  assign collision_blocks = coll_r;

endmodule

`default_nettype wire

### src/sparse_block_span_statistics.sv
// Top level of the sparse block span statistics block.
//
// The block takes the nonzero entries of a striped sparse matrix on in_chan, one
// request per entry carrying the row index, the column slot and a stripe end mark.
// Entries are grouped into blocks of the configured stride; each filled block
// updates the span statistics, and a stripe that ends in a short block counts as
// partial. Every entry produces exactly one result request on out_chan holding
// the running statistics after that entry.
// Registers are written on cfg_chan (address 0 stride, address 1 collision check
// off), which is always ready; writes are expected only while the block is idle.
// An accepted entry lands in an input register; when the result register frees up,
// the block tracking and statistics update and the result register loads, holding
// the result for out_chan. One entry is taken every cycle while the receiver does
// not stall: the only loop is the update of the tracking and counter registers.
// When the receiver stalls, the result register holds, the input register keeps
// its entry and in_chan.ready drops once both are occupied.
// Synchronous reset clears all statistics (minimum span to 2147483647), empties
// both pipeline registers and sets the stride to 1 with checking on.
`default_nettype none

module sparse_block_span_statistics import sbss_pkg::*; #(
  parameter int MAX_STRIDE = SBSS_MAX_STRIDE
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sbss_in_if.sink   in_chan,
  sbss_out_if.source out_chan,
  sbss_cfg_if.sink  cfg_chan
);

  localparam int FW = $clog2(MAX_STRIDE + 1);
  localparam int CW = (FW > STRIDE_W) ? FW : STRIDE_W;

  // Configuration registers.
  logic [STRIDE_W-1:0] stride_r;
  logic                check_off_r;
  logic [CW-1:0]       stride_ext, stride_eff;

  // Input register.
  logic              s1_valid_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_end_r;

  logic       out_valid_r;
  logic       advance, fire;
  blk_event_t ev;
  logic [CNT_W-1:0] span_le [N_LIMITS];

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r    <= STRIDE_W'(1);
      check_off_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.addr)
        CFG_STRIDE:    stride_r <= cfg_chan.data;
        CFG_CHECK_OFF: check_off_r <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // A stride of zero acts as one; anything above the maximum is clamped.
  always_comb begin
    stride_ext = CW'(stride_r);
    if (stride_ext == '0) begin
      stride_eff = CW'(1);
    end else if (stride_ext > CW'(MAX_STRIDE)) begin
      stride_eff = CW'(MAX_STRIDE);
    end else begin
      stride_eff = stride_ext;
    end
  end

  // The result register frees up when empty or taken; the input register moves
  // into it whenever it frees up.
  assign advance       = !out_valid_r || out_chan.ready;
  assign fire          = advance && s1_valid_r;
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_row_r  <= in_chan.row_index;
      s1_slot_r <= in_chan.slot;
      s1_end_r  <= in_chan.stripe_end;
    end
  end

  sbss_tracker #(
    .MAX_STRIDE(MAX_STRIDE)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .row_index  (s1_row_r),
    .slot       (s1_slot_r),
    .stripe_end (s1_end_r),
    .stride_eff (stride_eff),
    .check_off  (check_off_r),
    .ev         (ev)
  );

  sbss_stats u_stats (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .ev               (ev),
    .block_closed     (out_chan.block_closed),
    .full_blocks      (out_chan.full_blocks),
    .min_span         (out_chan.min_span),
    .max_span         (out_chan.max_span),
    .span_le          (span_le),
    .partial_blocks   (out_chan.partial_blocks),
    .collision_blocks (out_chan.collision_blocks)
  );

  assign out_chan.valid      = out_valid_r;
  assign out_chan.span_le_4  = span_le[0];
  assign out_chan.span_le_8  = span_le[1];
  assign out_chan.span_le_16 = span_le[2];
  assign out_chan.span_le_32 = span_le[3];

endmodule

`default_nettype wire
